@@ rtl/percentile_contrast_stretch_rgb_assert.svh @@
// ---------------------------------------------------------------------------
// percentile contrast stretch assertion macros
// shared assertion forms for the checker
// ---------------------------------------------------------------------------
`ifndef PERCENTILE_CONTRAST_STRETCH_RGB_ASSERT_SVH
`define PERCENTILE_CONTRAST_STRETCH_RGB_ASSERT_SVH

// same-cycle implication
`define PCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pcs assertion failed");

// next-cycle implication
`define PCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pcs assertion failed");

`endif

@@ rtl/pcs_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_pkg
// types and constants shared by the contrast stretch modules
// ---------------------------------------------------------------------------
package pcs_pkg;

    localparam int PIX_W     = 8;
    localparam int BINS      = 256;
    localparam int BIN_W     = 8;
    localparam int CNT_W     = 23;
    localparam int IDX_W     = 9;
    localparam int PCT_W     = 7;
    localparam int BASE_W    = 16;
    localparam int PROD_W    = 47;
    localparam int RECIP_SH  = 30;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 80;

    localparam logic [CNT_W-1:0] MAX_PIXELS = 23'd4194304;
    // ceil(2^30 / 100), exact quotient for any 23-bit count
    localparam logic [PROD_W-1:0] RECIP_100 = 47'd10737419;
    localparam logic [PCT_W-1:0] PCT_MAX    = 7'd100;
    localparam logic [PCT_W-1:0] LOW_PCT_RST  = 7'd1;
    localparam logic [PCT_W-1:0] HIGH_PCT_RST = 7'd99;

    localparam logic REG_LOW_PCT  = 1'b0;
    localparam logic REG_HIGH_PCT = 1'b1;

    localparam logic CMD_COUNT = 1'b0;
    localparam logic CMD_MAP   = 1'b1;

    localparam logic KIND_LIMITS = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    typedef struct packed {
        logic cap;
        logic clr_we;
        logic hist_re;
        logic hist_inc;
        logic thr_mul1;
        logic thr_mul2;
        logic scan_rd;
        logic scan_proc;
        logic div_init;
        logic div_step;
        logic build_init;
        logic build_wr;
        logic map_rd;
        logic out_rep;
        logic out_map;
    } t_cmd;

    typedef struct packed {
        logic in_cmd;
        logic last;
        logic out_free;
    } t_sts;

endpackage

@@ rtl/percentile_contrast_stretch_rgb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// percentile_contrast_stretch_rgb
// per-channel percentile contrast stretch on 8-bit bgr pixels
// ---------------------------------------------------------------------------
// Pixels enter on the s_ stream; s_tuser selects count (0) or map (1),
// s_tlast closes a counting pass. Counting a pixel is one
// histogram read and one write-back in the same ram per channel.
// On the last counted pixel the block finds the limits with one pass over
// the 256 bins (bins are zeroed behind the read), runs an 8-step divider
// for 255 / (high - low), then writes the 256 table entries, one a cycle.
// A map pixel takes one table read, then the output register.
// Results leave on the m_ stream from an output register; m_tuser is 0
// for a limits report and 1 for a mapped pixel. While a result waits,
// the next pixel is already taken in; a result that needs the output
// register stalls until m_tready frees it.
// After reset a clear pass over the 256 bins zeroes the histograms; s_tready stays low
// until it ends. Configuration writes are taken at any time.
// ---------------------------------------------------------------------------
module percentile_contrast_stretch_rgb (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [pcs_pkg::PCT_W-1:0]         i_cfg_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // blue_in, green_in, red_in
    input  logic [pcs_pkg::IN_DATA_W-1:0]     s_tdata,
    // cmd
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // blue_out, green_out, red_out, blue_low, green_low, red_low,
    // blue_high, green_high, red_high, count_overflow, zero pad
    output logic [pcs_pkg::OUT_DATA_W-1:0]    m_tdata,
    // kind
    output logic                              m_tuser
);
    import pcs_pkg::*;

    t_cmd             w_cmd;
    t_sts             w_sts;
    logic [IDX_W-1:0] w_idx;

    pcs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_idx   (w_idx)
    );

    pcs_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_idx     (w_idx),
        .o_sts     (w_sts),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

@@ rtl/pcs_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_ram
// simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module pcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pcs_lane.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_lane
// one color channel: histogram, limit scan, reciprocal step and lookup table
// ---------------------------------------------------------------------------
module pcs_lane (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  pcs_pkg::t_cmd                i_cmd,
    input  logic [pcs_pkg::IDX_W-1:0]    i_idx,
    input  logic [pcs_pkg::PIX_W-1:0]    i_pix,
    input  logic [pcs_pkg::CNT_W-1:0]    i_tl,
    input  logic [pcs_pkg::CNT_W-1:0]    i_th,
    output logic [pcs_pkg::PIX_W-1:0]    o_lo,
    output logic [pcs_pkg::PIX_W-1:0]    o_hi,
    output logic [pcs_pkg::PIX_W-1:0]    o_map
);
    import pcs_pkg::*;

    logic [CNT_W-1:0] w_hrd, w_hwd, w_cum_n;
    logic [BIN_W-1:0] w_hwa, w_hra, w_bin, w_v;
    logic             w_hwe, w_hre;

    logic [CNT_W-1:0] r_cum;
    logic [PIX_W-1:0] r_lo, r_hi;
    logic             r_found;
    logic [PIX_W-1:0] r_d, r_rem, r_quo, r_q;
    logic             r_flat;
    logic [9:0]       r_r;
    logic [8:0]       r_b2;

    logic [8:0]       w_rem_s;
    logic [9:0]       w_rs, w_rs_sub, w_two_d;
    logic [8:0]       w_qs;
    logic [PIX_W-1:0] w_qn, w_val;
    logic             w_in_rng;

    // histogram port selection
    assign w_bin = i_idx[BIN_W-1:0] - 8'd1;
    assign w_hwe = i_cmd.clr_we | i_cmd.hist_inc | i_cmd.scan_proc;
    assign w_hwa = i_cmd.clr_we ? i_idx[BIN_W-1:0] : (i_cmd.hist_inc ? i_pix : w_bin);
    assign w_hwd = i_cmd.hist_inc ? w_hrd + 23'd1 : '0;
    assign w_hre = i_cmd.hist_re | i_cmd.scan_rd;
    assign w_hra = i_cmd.hist_re ? i_pix : i_idx[BIN_W-1:0];

    pcs_ram #(.WIDTH(CNT_W), .DEPTH(BINS)) u_hist (
        .i_clk  (i_clk),
        .i_we   (w_hwe),
        .i_waddr(w_hwa),
        .i_wdata(w_hwd),
        .i_re   (w_hre),
        .i_raddr(w_hra),
        .o_rdata(w_hrd)
    );

    assign w_cum_n = r_cum + w_hrd;

    // limit scan, bins are cleared behind the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lo    <= '0;
            r_hi    <= '0;
            r_found <= 1'b0;
            r_cum   <= '0;
        end else if (i_cmd.thr_mul2) begin
            r_lo    <= '0;
            r_hi    <= '0;
            r_found <= 1'b0;
            r_cum   <= '0;
        end else if (i_cmd.scan_proc) begin
            r_cum <= w_cum_n;
            if (!r_found) begin
                if (w_cum_n <= i_tl) begin
                    r_lo <= (w_bin == 8'd255) ? 8'd255 : w_bin + 8'd1;
                end
                if (w_cum_n >= i_th) begin
                    r_hi    <= w_bin;
                    r_found <= 1'b1;
                end
            end
        end
    end

    // 255 / d, one quotient bit per step
    assign w_rem_s = {r_rem, 1'b1};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_d    <= r_hi - r_lo;
            r_flat <= (r_hi <= r_lo);
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (i_cmd.div_step) begin
            if (w_rem_s >= {1'b0, r_d}) begin
                r_rem <= 8'(w_rem_s - {1'b0, r_d});
                r_quo <= {r_quo[6:0], 1'b1};
            end else begin
                r_rem <= w_rem_s[7:0];
                r_quo <= {r_quo[6:0], 1'b0};
            end
        end
    end

    // table build: quotient and remainder of (510x + d) / 2d tracked per step
    assign w_v      = i_idx[BIN_W-1:0];
    assign w_two_d  = {1'b0, r_d, 1'b0};
    assign w_rs     = r_r + {1'b0, r_b2};
    assign w_rs_sub = w_rs - w_two_d;
    assign w_qs     = {1'b0, r_q} + {1'b0, r_quo} + ((w_rs >= w_two_d) ? 9'd1 : 9'd0);
    assign w_qn     = w_qs[7:0];
    assign w_in_rng = (w_v > r_lo) && (w_v <= r_hi);

    always_comb begin
        if (r_flat) begin
            w_val = (w_v >= r_hi) ? 8'd255 : 8'd0;
        end else if (w_in_rng) begin
            w_val = w_qn;
        end else begin
            w_val = r_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.build_init) begin
            r_q  <= '0;
            r_r  <= {2'b0, r_d};
            r_b2 <= {r_rem, 1'b0};
        end else if (i_cmd.build_wr && !r_flat && w_in_rng) begin
            r_q <= w_qn;
            r_r <= (w_rs >= w_two_d) ? w_rs_sub : w_rs;
        end
    end

    pcs_ram #(.WIDTH(PIX_W), .DEPTH(BINS)) u_table (
        .i_clk  (i_clk),
        .i_we   (i_cmd.build_wr),
        .i_waddr(w_v),
        .i_wdata(w_val),
        .i_re   (i_cmd.map_rd),
        .i_raddr(i_pix),
        .o_rdata(o_map)
    );

    assign o_lo = r_lo;
    assign o_hi = r_hi;

endmodule

@@ rtl/pcs_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_dp
// datapath: config registers, pixel count, thresholds, lanes, output stage
// ---------------------------------------------------------------------------
module pcs_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  pcs_pkg::t_cmd                     i_cmd,
    input  logic [pcs_pkg::IDX_W-1:0]         i_idx,
    output pcs_pkg::t_sts                     o_sts,
    input  logic                              i_cfg_we,
    input  logic                              i_cfg_idx,
    input  logic [pcs_pkg::PCT_W-1:0]         i_cfg_data,
    input  logic [pcs_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pcs_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tuser
);
    import pcs_pkg::*;

    logic [PCT_W-1:0]  r_low_pct, r_high_pct, w_lp, w_hp;
    logic [CNT_W-1:0]  r_total;
    logic              r_ovf;
    logic [PIX_W-1:0]  r_pix [3];
    logic              r_last;
    logic [PROD_W-1:0] w_prod;
    logic [BASE_W-1:0] r_base;
    logic [CNT_W-1:0]  r_tl, r_th;
    logic              w_sat;
    t_cmd              w_lcmd;
    logic [PIX_W-1:0]  w_lo [3];
    logic [PIX_W-1:0]  w_hi [3];
    logic [PIX_W-1:0]  w_map [3];
    logic              r_m_valid, r_m_user;
    logic [OUT_DATA_W-1:0] r_m_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_pct  <= LOW_PCT_RST;
            r_high_pct <= HIGH_PCT_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_LOW_PCT) begin
                r_low_pct <= i_cfg_data;
            end
            if (i_cfg_idx == REG_HIGH_PCT) begin
                r_high_pct <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_pix[0] <= s_tdata[7:0];
            r_pix[1] <= s_tdata[15:8];
            r_pix[2] <= s_tdata[23:16];
            r_last   <= s_tlast;
        end
    end

    assign w_sat = (r_total == MAX_PIXELS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.out_rep) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else if (i_cmd.hist_inc) begin
            if (w_sat) begin
                r_ovf <= 1'b1;
            end else begin
                r_total <= r_total + 23'd1;
            end
        end
    end

    // count / 100 by reciprocal, then scaled by the clipped percentages
    assign w_prod = PROD_W'(r_total) * RECIP_100;
    assign w_lp   = (r_low_pct > PCT_MAX) ? PCT_MAX : r_low_pct;
    assign w_hp   = (r_high_pct > PCT_MAX) ? PCT_MAX : r_high_pct;

    always_ff @(posedge i_clk) begin
        if (i_cmd.thr_mul1) begin
            r_base <= w_prod[RECIP_SH+BASE_W-1:RECIP_SH];
        end
        if (i_cmd.thr_mul2) begin
            r_tl <= CNT_W'(r_base) * CNT_W'(w_lp);
            r_th <= CNT_W'(r_base) * CNT_W'(w_hp);
        end
    end

    always_comb begin
        w_lcmd          = i_cmd;
        w_lcmd.hist_inc = i_cmd.hist_inc & ~w_sat;
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        pcs_lane u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (w_lcmd),
            .i_idx  (i_idx),
            .i_pix  (r_pix[g]),
            .i_tl   (r_tl),
            .i_th   (r_th),
            .o_lo   (w_lo[g]),
            .o_hi   (w_hi[g]),
            .o_map  (w_map[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_rep || i_cmd.out_map) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_rep) begin
            r_m_user <= KIND_LIMITS;
            r_m_data <= {7'b0, r_ovf, w_hi[2], w_hi[1], w_hi[0],
                         w_lo[2], w_lo[1], w_lo[0], 24'b0};
        end else if (i_cmd.out_map) begin
            r_m_user <= KIND_PIXEL;
            r_m_data <= {7'b0, 1'b0, w_hi[2], w_hi[1], w_hi[0],
                         w_lo[2], w_lo[1], w_lo[0], w_map[2], w_map[1], w_map[0]};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tuser  = r_m_user;
    assign m_tdata  = r_m_data;

    assign o_sts.in_cmd   = s_tuser;
    assign o_sts.last     = r_last;
    assign o_sts.out_free = ~r_m_valid | m_tready;

endmodule

@@ rtl/pcs_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_ctrl
// sequencer for counting, limit search, table build and lookup
// ---------------------------------------------------------------------------
module pcs_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  pcs_pkg::t_sts                i_sts,
    output pcs_pkg::t_cmd                o_cmd,
    output logic [pcs_pkg::IDX_W-1:0]    o_idx
);
    import pcs_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_CNT_RD, S_CNT_WR, S_THR1, S_THR2, S_SCAN,
        S_DINIT, S_DIV, S_BINIT, S_BUILD, S_REP, S_MAP_RD, S_MAP_OUT
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_cmd             w_cmd;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        w_cmd    = '0;
        s_tready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_cmd.clr_we = 1'b1;
                n_idx = r_idx + 9'd1;
                if (r_idx == 9'd255) begin
                    n_idx   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    w_cmd.cap = 1'b1;
                    n_state = (i_sts.in_cmd == CMD_MAP) ? S_MAP_RD : S_CNT_RD;
                end
            end
            S_CNT_RD: begin
                w_cmd.hist_re = 1'b1;
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                w_cmd.hist_inc = 1'b1;
                n_state = i_sts.last ? S_THR1 : S_IDLE;
            end
            S_THR1: begin
                w_cmd.thr_mul1 = 1'b1;
                n_state = S_THR2;
            end
            S_THR2: begin
                w_cmd.thr_mul2 = 1'b1;
                n_idx   = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // read leads processing by one bin
                w_cmd.scan_rd   = ~r_idx[8];
                w_cmd.scan_proc = (r_idx != '0);
                n_idx = r_idx + 9'd1;
                if (r_idx[8]) begin
                    n_idx   = '0;
                    n_state = S_DINIT;
                end
            end
            S_DINIT: begin
                w_cmd.div_init = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                w_cmd.div_step = 1'b1;
                n_idx = r_idx + 9'd1;
                if (r_idx == 9'd7) begin
                    n_idx   = '0;
                    n_state = S_BINIT;
                end
            end
            S_BINIT: begin
                w_cmd.build_init = 1'b1;
                n_state = S_BUILD;
            end
            S_BUILD: begin
                w_cmd.build_wr = 1'b1;
                n_idx = r_idx + 9'd1;
                if (r_idx == 9'd255) begin
                    n_idx   = '0;
                    n_state = S_REP;
                end
            end
            S_REP: begin
                if (i_sts.out_free) begin
                    w_cmd.out_rep = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_MAP_RD: begin
                w_cmd.map_rd = 1'b1;
                n_state = S_MAP_OUT;
            end
            S_MAP_OUT: begin
                if (i_sts.out_free) begin
                    w_cmd.out_map = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_cmd = w_cmd;
    assign o_idx = r_idx;

endmodule

@@ rtl/pcs_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcs_checker
// port-level checks for the contrast stretch block
// ---------------------------------------------------------------------------
`include "percentile_contrast_stretch_rgb_assert.svh"

module pcs_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pcs_pkg::OUT_DATA_W-1:0]    m_tdata,
    input logic                              m_tuser
);
    import pcs_pkg::*;

    `PCS_ASSERT_NEXT(a_m_hold, i_clk, i_rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // a mapped pixel never reports overflow, and padding stays zero
    `PCS_ASSERT_SAME(a_map_fields, i_clk, i_rst_n, m_tvalid && (m_tuser == KIND_PIXEL), m_tdata[79:72] == 8'd0)
    // a limits report carries zero pixel bytes and zero padding
    `PCS_ASSERT_SAME(a_rep_fields, i_clk, i_rst_n, m_tvalid && (m_tuser == KIND_LIMITS), m_tdata[23:0] == 24'd0 && m_tdata[79:73] == 7'd0)
    // s_tready is low in the cycle after every accepted pixel
    `PCS_ASSERT_NEXT(a_busy_after, i_clk, i_rst_n, s_tvalid && s_tready, !s_tready)
    // histogram clear pass runs right after reset
    `PCS_ASSERT_SAME(a_clear_pass, i_clk, i_rst_n, !$past(i_rst_n), !s_tready)

endmodule

bind percentile_contrast_stretch_rgb pcs_checker u_pcs_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);

@@ dv/percentile_contrast_stretch_rgb_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// percentile_contrast_stretch_rgb_tb
// self-checking bench: counting frames and map pixels go in as directed and
// random transactions, a class predicts limits reports and mapped pixels and
// compares every output transaction field by field
// ---------------------------------------------------------------------------
module percentile_contrast_stretch_rgb_tb;
    import pcs_pkg::*;

    typedef struct {
        logic       kind;
        logic [7:0] pix_out [3];
        logic [7:0] lim_lo [3];
        logic [7:0] lim_hi [3];
        logic       ovf;
    } t_stretch_res;

    class t_stretch_scoreboard;
        int unsigned hist [3][256];
        int unsigned npix;
        bit          ovf;
        logic [7:0]  lo_lim [3];
        logic [7:0]  hi_lim [3];
        logic [7:0]  lut [3][256];
        int unsigned lo_pct;
        int unsigned hi_pct;
        t_stretch_res pending [$];
        int          n_err;

        function new();
            for (int c = 0; c < 3; c++) begin
                lo_lim[c] = 0;
                hi_lim[c] = 0;
                for (int b = 0; b < 256; b++) begin
                    hist[c][b] = 0;
                    lut[c][b] = 0;
                end
            end
            npix = 0;
            ovf = 0;
            lo_pct = 1;
            hi_pct = 99;
            n_err = 0;
        endfunction

        function void set_reg(logic idx, logic [6:0] val);
            if (idx == REG_LOW_PCT) lo_pct = val;
            else hi_pct = val;
        endfunction

        function void rebuild(int unsigned t_lo, int unsigned t_hi);
            int unsigned cum, lo, hi, d, x;
            for (int c = 0; c < 3; c++) begin
                cum = 0;
                lo = 0;
                hi = 0;
                for (int b = 0; b < 256; b++) begin
                    cum += hist[c][b];
                    if (cum <= t_lo) lo = (b + 1 > 255) ? 255 : b + 1;
                    if (cum >= t_hi) begin
                        hi = b;
                        break;
                    end
                end
                lo_lim[c] = 8'(lo);
                hi_lim[c] = 8'(hi);
                for (int v = 0; v < 256; v++) begin
                    if (hi <= lo) begin
                        lut[c][v] = (v >= hi) ? 8'd255 : 8'd0;
                    end else begin
                        d = hi - lo;
                        x = (v < lo) ? lo : ((v > hi) ? hi : v);
                        x -= lo;
                        lut[c][v] = 8'((2 * x * 255 + d) / (2 * d));
                    end
                end
                for (int b = 0; b < 256; b++) hist[c][b] = 0;
            end
        endfunction

        function void note_pixel(logic cmd, logic [7:0] px [3], logic lst);
            t_stretch_res r;
            int unsigned base;
            if (cmd == CMD_MAP) begin
                r.kind = KIND_PIXEL;
                for (int c = 0; c < 3; c++) begin
                    r.pix_out[c] = lut[c][px[c]];
                    r.lim_lo[c] = lo_lim[c];
                    r.lim_hi[c] = hi_lim[c];
                end
                r.ovf = 0;
                pending.push_back(r);
                return;
            end
            if (npix < MAX_PIXELS) begin
                for (int c = 0; c < 3; c++) hist[c][px[c]]++;
                npix++;
            end else begin
                ovf = 1;
            end
            if (!lst) return;
            base = npix / 100;
            rebuild(base * ((lo_pct > 100) ? 100 : lo_pct),
                    base * ((hi_pct > 100) ? 100 : hi_pct));
            r.kind = KIND_LIMITS;
            for (int c = 0; c < 3; c++) begin
                r.pix_out[c] = 0;
                r.lim_lo[c] = lo_lim[c];
                r.lim_hi[c] = hi_lim[c];
            end
            r.ovf = ovf;
            pending.push_back(r);
            npix = 0;
            ovf = 0;
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s expected %0d actual %0d", name, exp_v, act_v);
                n_err++;
            end
        endfunction

        function void check_result(logic kind, logic [OUT_DATA_W-1:0] d);
            t_stretch_res e;
            string ch [3] = '{"blue", "green", "red"};
            if (pending.size() == 0) begin
                $error("unexpected result transaction kind %0d", kind);
                n_err++;
                return;
            end
            e = pending.pop_front();
            cmp("kind", e.kind, kind);
            for (int c = 0; c < 3; c++) begin
                cmp({ch[c], "_out"}, e.pix_out[c], d[c*8 +: 8]);
                cmp({ch[c], "_low"}, e.lim_lo[c], d[24 + c*8 +: 8]);
                cmp({ch[c], "_high"}, e.lim_hi[c], d[48 + c*8 +: 8]);
            end
            cmp("count_overflow", e.ovf, d[72]);
        endfunction
    endclass

    logic i_clk, i_rst_n;
    logic i_cfg_we, i_cfg_idx;
    logic [PCT_W-1:0] i_cfg_data;
    logic s_tvalid, s_tready, s_tuser, s_tlast;
    logic [IN_DATA_W-1:0] s_tdata;
    logic m_tvalid, m_tready, m_tuser;
    logic [OUT_DATA_W-1:0] m_tdata;

    t_stretch_scoreboard sb;
    int  idle_cycles;
    bit  hold_off;

    percentile_contrast_stretch_rgb u_top (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(logic cmd, logic [7:0] b, logic [7:0] g,
                              logic [7:0] r, logic lst);
        logic [7:0] px [3];
        int n;
        n = gap_len();
        // the block is busy after a transaction anyway
        repeat (n + 1) @(negedge i_clk);
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= {r, g, b};
        s_tlast <= lst;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        px[0] = b;
        px[1] = g;
        px[2] = r;
        sb.note_pixel(cmd, px, lst);
        @(negedge i_clk);
        s_tvalid <= 0;
    endtask

    task automatic write_reg(logic idx, logic [6:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        sb.set_reg(idx, val);
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    // frame of n count pixels; narrow pixels cluster the histogram
    task automatic count_frame(int n, bit narrow);
        logic [7:0] v [3];
        for (int i = 0; i < n; i++) begin
            for (int c = 0; c < 3; c++)
                v[c] = narrow ? 8'($urandom_range(60, 140)) : 8'($urandom_range(0, 255));
            send_pixel(CMD_COUNT, v[0], v[1], v[2], i == n - 1);
        end
    endtask

    task automatic map_burst(int n);
        for (int i = 0; i < n; i++)
            send_pixel(CMD_MAP, 8'($urandom), 8'($urandom), 8'($urandom),
                       1'($urandom_range(0, 1)));
    endtask

    // receiver: random stalls, with one long hold-off on request
    initial begin
        m_tready = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_tready <= 0;
                repeat (300) @(negedge i_clk);
                hold_off = 0;
            end else if ($urandom_range(0, 99) < 25) begin
                m_tready <= 0;
                repeat (gap_len()) @(negedge i_clk);
            end else begin
                m_tready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("percentile_contrast_stretch_rgb_tb: errors");
            $finish;
        end
    end

    initial begin
        sb = new();
        hold_off = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = REG_LOW_PCT;
        i_cfg_data = 0;
        s_tvalid = 0;
        s_tuser = CMD_COUNT;
        s_tdata = 0;
        s_tlast = 0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: default percents, extremes of the pixel bytes
        send_pixel(CMD_COUNT, 8'h00, 8'hff, 8'h55, 1'b0);
        send_pixel(CMD_COUNT, 8'hff, 8'h00, 8'haa, 1'b0);
        send_pixel(CMD_COUNT, 8'h80, 8'h7f, 8'h01, 1'b1);
        send_pixel(CMD_MAP, 8'h00, 8'hff, 8'h80, 1'b1);
        send_pixel(CMD_MAP, 8'hff, 8'h00, 8'h7f, 1'b0);
        drain();
        // empty frame equivalent: single pixel, zero thresholds
        write_reg(REG_LOW_PCT, 7'd0);
        write_reg(REG_HIGH_PCT, 7'd0);
        send_pixel(CMD_COUNT, 8'h10, 8'h20, 8'h30, 1'b1);
        send_pixel(CMD_MAP, 8'h10, 8'h20, 8'h00, 1'b0);
        drain();
        // percent above 100 clipped
        write_reg(REG_LOW_PCT, 7'd127);
        write_reg(REG_HIGH_PCT, 7'd127);
        count_frame(100, 1'b0);
        map_burst(6);
        drain();
        write_reg(REG_LOW_PCT, 7'd100);
        write_reg(REG_HIGH_PCT, 7'd100);
        count_frame(100, 1'b1);
        map_burst(4);
        drain();

        // random phases
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_LOW_PCT, 7'($urandom_range(0, 20)));
            write_reg(REG_HIGH_PCT, 7'($urandom_range(60, 100)));
            count_frame($urandom_range(40, 80), 1'($urandom_range(0, 1)));
            if (ph == 2) hold_off = 1;
            map_burst($urandom_range(10, 25));
            drain();
        end

        if (sb.n_err == 0) begin
            $display("percentile_contrast_stretch_rgb_tb: clean");
        end else begin
            $display("percentile_contrast_stretch_rgb_tb: errors");
        end
        $finish;
    end
endmodule
